FILE: design/nss_pkg.sv
// Shared constants, codes and controller/datapath interface types for the nearest segment search.
`timescale 1ns / 1ps
package nss_pkg;

  // Store geometry.
  localparam int MAX_SEGMENTS = 64;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = IDX_W + 1;

  // Field widths.
  localparam int MODE_W  = 2;
  localparam int COORD_W = 16;
  localparam int SEG_W   = 4 * COORD_W;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int OP_W    = DIFF_W + 1;
  localparam int PROD_W  = 2 * OP_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int MAG_W   = 33;
  localparam int LEN2_W  = 34;
  localparam int DIST_W  = 25;

  // Square root search widths.
  localparam int SQ_W      = 84;
  localparam int CAND_W    = SQ_W + 2;
  localparam int ROOT_BITS = DIST_W;
  localparam int BIT_W     = $clog2(ROOT_BITS);

  // Special distances.
  localparam logic [DIST_W-1:0] DIST_MAX     = {DIST_W{1'b1}};
  localparam logic [DIST_W-1:0] OUTSIDE_DIST = DIST_W'(100 * 256);

  // Request modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  // Multiply sequence steps.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_DOTA_LO  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_DOTA_HI  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_DOTB_LO  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_DOTB_HI  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_LEN_LO   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_LEN_HI   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_CROSS_LO = 4'd6;
  localparam logic [STEP_W-1:0] STEP_CROSS_HI = 4'd7;
  localparam logic [STEP_W-1:0] STEP_ABS      = 4'd8;
  localparam logic [STEP_W-1:0] STEP_SQ_HH    = 4'd9;
  localparam logic [STEP_W-1:0] STEP_SQ_HL    = 4'd10;
  localparam logic [STEP_W-1:0] STEP_SQ_LL    = 4'd11;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             latch_pt;
    logic             rd_en;
    logic [IDX_W-1:0] idx;
    logic             diff_en;
    logic             mul_en;
    logic [STEP_W-1:0] mul_step;
    logic             root_init;
    logic             root_sum;
    logic             root_upd;
    logic             cmp_en;
    logic             load_out;
    logic             out_found;
  } nss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip;
  } nss_stat_t;

endpackage

FILE: design/nss_ctrl.sv
// Controller state machine: request decode, segment walk and result handoff.
`timescale 1ns / 1ps
module nss_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [nss_pkg::MODE_W-1:0]  in_mode,
  output logic                        out_valid,
  input  logic                        out_ready,
  output nss_pkg::nss_cmd_t           cmd,
  input  nss_pkg::nss_stat_t          stat
);
  import nss_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_READ = 7'b0000010,
    ST_DIFF = 7'b0000100,
    ST_MUL  = 7'b0001000,
    ST_ROOT = 7'b0010000,
    ST_CMP  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;
  logic               phase_r, phase_nxt;
  logic               empty_r, empty_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               accept;
  logic               last_idx;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign last_idx  = (CNT_W'({1'b0, idx_r}) + CNT_W'(1)) == count_r;

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    bit_nxt       = bit_r;
    phase_nxt     = phase_r;
    empty_nxt     = empty_r;
    cmd           = '0;
    cmd.wr_addr   = count_r[IDX_W-1:0];
    cmd.idx       = idx_r;
    cmd.mul_step  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (mode_t'(in_mode))
            MODE_CLEAR: begin
              count_nxt = '0;
            end
            MODE_APPEND: begin
              if (count_r < CNT_W'(MAX_SEGMENTS)) begin
                cmd.wr_en = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            MODE_QUERY: begin
              cmd.latch_pt = 1'b1;
              idx_nxt      = '0;
              if (count_r == '0) begin
                empty_nxt = 1'b1;
                state_nxt = ST_DONE;
              end else begin
                empty_nxt = 1'b0;
                state_nxt = ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff_en = 1'b1;
        step_nxt    = '0;
        state_nxt   = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        if (step_r == STEP_SQ_LL) begin
          cmd.root_init = 1'b1;
          bit_nxt       = '0;
          phase_nxt     = 1'b0;
          state_nxt     = stat.skip ? ST_CMP : ST_ROOT;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_ROOT: begin
        if (!phase_r) begin
          cmd.root_sum = 1'b1;
          phase_nxt    = 1'b1;
        end else begin
          cmd.root_upd = 1'b1;
          phase_nxt    = 1'b0;
          if (bit_r == BIT_W'(ROOT_BITS - 1)) begin
            state_nxt = ST_CMP;
          end else begin
            bit_nxt = bit_r + BIT_W'(1);
          end
        end
      end
      ST_CMP: begin
        cmd.cmp_en = 1'b1;
        if (last_idx) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = ST_READ;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          cmd.out_found = !empty_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result valid flag.
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      step_r      <= '0;
      bit_r       <= '0;
      phase_r     <= 1'b0;
      empty_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      step_r      <= step_nxt;
      bit_r       <= bit_nxt;
      phase_r     <= phase_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: design/nss_dp.sv
// Datapath: segment memory, shared multiplier, square root search and minimum tracking.
`timescale 1ns / 1ps
module nss_dp (
  input  logic                                clk,
  input  logic signed [nss_pkg::COORD_W-1:0]  in_start_x,
  input  logic signed [nss_pkg::COORD_W-1:0]  in_start_y,
  input  logic signed [nss_pkg::COORD_W-1:0]  in_end_x,
  input  logic signed [nss_pkg::COORD_W-1:0]  in_end_y,
  input  nss_pkg::nss_cmd_t                   cmd,
  output nss_pkg::nss_stat_t                  stat,
  output logic                                out_found,
  output logic [nss_pkg::IDX_W-1:0]           out_segment_index,
  output logic [nss_pkg::DIST_W-1:0]          out_distance
);
  import nss_pkg::*;

  logic [SEG_W-1:0]          seg_mem [MAX_SEGMENTS];
  logic [SEG_W-1:0]          rd_data_r;
  logic [COORD_W-1:0]        px_r, py_r;
  logic [COORD_W-1:0]        ax, ay, bx, by;
  logic signed [DIFF_W-1:0]  dx_r, dy_r, pax_r, pay_r, pbx_r, pby_r;
  logic signed [OP_W-1:0]    op_a, op_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc_r, acc_sum, acc_diff, acc_neg, prod_ext;
  logic                      neg_r;
  logic [LEN2_W-1:0]         len2_r;
  logic [MAG_W-1:0]          mag_r;
  logic [SQ_W-1:0]           msq_r, prod_sq;
  logic [SQ_W-1:0]           s_r, v_r, u_r;
  logic [CAND_W-1:0]         cand_r;
  logic                      take;
  logic [DIST_W-1:0]         d_r, cur_dist;
  logic [DIST_W-1:0]         best_d_r;
  logic [IDX_W-1:0]          best_i_r;
  logic                      out_found_r;
  logic [IDX_W-1:0]          out_idx_r;
  logic [DIST_W-1:0]         out_dist_r;

  // Segment memory with registered read.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      seg_mem[cmd.wr_addr] <= {in_end_y, in_end_x, in_start_y, in_start_x};
    end
    if (cmd.rd_en) begin
      rd_data_r <= seg_mem[cmd.idx];
    end
  end

  // Query point.
  always_ff @(posedge clk) begin
    if (cmd.latch_pt) begin
      px_r <= in_start_x;
      py_r <= in_start_y;
    end
  end

  assign ax = rd_data_r[COORD_W-1:0];
  assign ay = rd_data_r[2*COORD_W-1:COORD_W];
  assign bx = rd_data_r[3*COORD_W-1:2*COORD_W];
  assign by = rd_data_r[4*COORD_W-1:3*COORD_W];

  // Coordinate differences.
  always_ff @(posedge clk) begin
    if (cmd.diff_en) begin
      dx_r  <= $signed({bx[COORD_W-1], bx} - {ax[COORD_W-1], ax});
      dy_r  <= $signed({by[COORD_W-1], by} - {ay[COORD_W-1], ay});
      pax_r <= $signed({px_r[COORD_W-1], px_r} - {ax[COORD_W-1], ax});
      pay_r <= $signed({py_r[COORD_W-1], py_r} - {ay[COORD_W-1], ay});
      pbx_r <= $signed({px_r[COORD_W-1], px_r} - {bx[COORD_W-1], bx});
      pby_r <= $signed({py_r[COORD_W-1], py_r} - {by[COORD_W-1], by});
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd.mul_step)
      STEP_DOTA_LO: begin
        op_a = $signed({dx_r[DIFF_W-1], dx_r});
        op_b = $signed({pax_r[DIFF_W-1], pax_r});
      end
      STEP_DOTA_HI: begin
        op_a = $signed({dy_r[DIFF_W-1], dy_r});
        op_b = $signed({pay_r[DIFF_W-1], pay_r});
      end
      STEP_DOTB_LO: begin
        op_a = $signed({dx_r[DIFF_W-1], dx_r});
        op_b = $signed({pbx_r[DIFF_W-1], pbx_r});
      end
      STEP_DOTB_HI: begin
        op_a = $signed({dy_r[DIFF_W-1], dy_r});
        op_b = $signed({pby_r[DIFF_W-1], pby_r});
      end
      STEP_LEN_LO: begin
        op_a = $signed({dx_r[DIFF_W-1], dx_r});
        op_b = $signed({dx_r[DIFF_W-1], dx_r});
      end
      STEP_LEN_HI: begin
        op_a = $signed({dy_r[DIFF_W-1], dy_r});
        op_b = $signed({dy_r[DIFF_W-1], dy_r});
      end
      STEP_CROSS_LO: begin
        op_a = $signed({dy_r[DIFF_W-1], dy_r});
        op_b = $signed({pax_r[DIFF_W-1], pax_r});
      end
      STEP_CROSS_HI: begin
        op_a = $signed({dx_r[DIFF_W-1], dx_r});
        op_b = $signed({pay_r[DIFF_W-1], pay_r});
      end
      STEP_SQ_HH: begin
        op_a = $signed({2'b00, mag_r[MAG_W-1:17]});
        op_b = $signed({2'b00, mag_r[MAG_W-1:17]});
      end
      STEP_SQ_HL: begin
        op_a = $signed({2'b00, mag_r[MAG_W-1:17]});
        op_b = $signed({1'b0, mag_r[16:0]});
      end
      STEP_SQ_LL: begin
        op_a = $signed({1'b0, mag_r[16:0]});
        op_b = $signed({1'b0, mag_r[16:0]});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod     = op_a * op_b;
  assign prod_ext = $signed({prod[PROD_W-1], prod});
  assign acc_sum  = acc_r + prod_ext;
  assign acc_diff = acc_r - prod_ext;
  assign acc_neg  = -acc_r;
  assign prod_sq  = SQ_W'(prod[PROD_W-2:0]);

  // Dot products, squared length, cross product and its square.
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_step)
        STEP_DOTA_LO, STEP_DOTB_LO, STEP_LEN_LO, STEP_CROSS_LO: begin
          acc_r <= prod_ext;
        end
        STEP_DOTA_HI: begin
          neg_r <= acc_sum[ACC_W-1];
        end
        STEP_DOTB_HI: begin
          // The far-end dot product is the negated sum.
          neg_r <= neg_r || (!acc_sum[ACC_W-1] && (acc_sum != '0));
        end
        STEP_LEN_HI: begin
          len2_r <= acc_sum[LEN2_W-1:0];
        end
        STEP_CROSS_HI: begin
          acc_r <= acc_diff;
        end
        STEP_ABS: begin
          mag_r <= acc_r[ACC_W-1] ? acc_neg[MAG_W-1:0] : acc_r[MAG_W-1:0];
        end
        STEP_SQ_HH: begin
          msq_r <= prod_sq << 50;
        end
        STEP_SQ_HL: begin
          msq_r <= msq_r + (prod_sq << 34);
        end
        STEP_SQ_LL: begin
          msq_r <= msq_r + (prod_sq << 16);
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.skip = neg_r || (len2_r == '0);

  // Bitwise root search: largest d with d*d*len2 <= msq, with a sum phase and an update phase per bit.
  assign take = (cand_r <= CAND_W'(msq_r));

  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      s_r <= '0;
      v_r <= '0;
      u_r <= SQ_W'(len2_r) << (2 * (ROOT_BITS - 1));
      d_r <= '0;
    end else if (cmd.root_sum) begin
      cand_r <= CAND_W'(s_r) + CAND_W'(v_r) + CAND_W'(u_r);
    end else if (cmd.root_upd) begin
      if (take) begin
        s_r <= cand_r[SQ_W-1:0];
        v_r <= (v_r >> 1) + u_r;
      end else begin
        v_r <= v_r >> 1;
      end
      u_r <= u_r >> 2;
      d_r <= {d_r[DIST_W-2:0], take};
    end
  end

  // Segment distance and running minimum.
  always_comb begin
    if (neg_r) begin
      cur_dist = OUTSIDE_DIST;
    end else if (len2_r == '0) begin
      cur_dist = DIST_MAX;
    end else begin
      cur_dist = d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp_en && ((cmd.idx == '0) || (cur_dist < best_d_r))) begin
      best_d_r <= cur_dist;
      best_i_r <= cmd.idx;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_found_r <= cmd.out_found;
      out_idx_r   <= cmd.out_found ? best_i_r : '0;
      out_dist_r  <= cmd.out_found ? best_d_r : '0;
    end
  end

  assign out_found         = out_found_r;
  assign out_segment_index = out_idx_r;
  assign out_distance      = out_dist_r;

endmodule

FILE: design/nearest_segment_search_top.sv
// Top level of the nearest segment search: controller, datapath and checks.
`timescale 1ns / 1ps
// A clear or an append request is taken while idle and the block is ready again the next
// cycle; an append to a full store of MAX_SEGMENTS segments is dropped. A query walks the N
// stored segments one at a time: each segment needs a memory read, a difference step,
// twelve steps of the shared 18x18 multiplier for the dot products, squared length and
// squared cross product, and then a bitwise square root search over 25 distance bits, with
// a sum phase and an update phase per bit. A segment whose foot falls outside it, or that
// has zero length, skips the root search. A query on an empty store answers with found low.
// The result sits in an output register, so a new request is taken while a result waits to
// be collected.
module nearest_segment_search_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [nss_pkg::MODE_W-1:0]          in_mode,
  input  logic signed [nss_pkg::COORD_W-1:0]  in_start_x,
  input  logic signed [nss_pkg::COORD_W-1:0]  in_start_y,
  input  logic signed [nss_pkg::COORD_W-1:0]  in_end_x,
  input  logic signed [nss_pkg::COORD_W-1:0]  in_end_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_found,
  output logic [nss_pkg::IDX_W-1:0]           out_segment_index,
  output logic [nss_pkg::DIST_W-1:0]          out_distance
);
  import nss_pkg::*;

  nss_cmd_t  cmd;
  nss_stat_t stat;

  // Controller.
  nss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Datapath.
  nss_dp u_dp (
    .clk               (clk),
    .in_start_x        (in_start_x),
    .in_start_y        (in_start_y),
    .in_end_x          (in_end_x),
    .in_end_y          (in_end_y),
    .cmd               (cmd),
    .stat              (stat),
    .out_found         (out_found),
    .out_segment_index (out_segment_index),
    .out_distance      (out_distance)
  );

`ifndef SYNTH
  // A query request makes the block busy in the cycle after it is taken.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_mode == MODE_QUERY)) |=> !in_ready)
    else $error("query request did not make the block busy");

  // A clear request completes at once.
  a_clear_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_mode == MODE_CLEAR)) |=> in_ready)
    else $error("clear request did not complete in one cycle");

  // A result without a stored segment carries zero index and distance.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> ((out_segment_index == '0) && (out_distance == '0)))
    else $error("empty result carries nonzero fields");
`endif

endmodule
